[hw/rtl/assert_macros.svh]
// assertion helpers for hashed_key_value_table.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define KVT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// clocked check that also holds during reset
`define KVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/kvt_pkg.sv]
package kvt_pkg;

	// slot count must be a power of two: the home slot is the low bits of the hash
	localparam int SLOTS      = 256;
	localparam int SLOT_BITS  = $clog2(SLOTS);
	localparam int KEY_BYTES  = 8;
	localparam int KEY_W      = 64;
	localparam int VALUE_W    = 32;
	localparam int ENTRY_W    = KEY_W + VALUE_W;
	localparam int LEN_W      = $clog2(KEY_BYTES + 1);
	localparam int COUNT_W    = $clog2(SLOTS + 1);
	localparam int SLOT_OUT_W = 8;
	// count*10 > SLOTS*7 is the same as count > floor(SLOTS*7/10)
	localparam int LOAD_LIMIT = SLOTS * 7 / 10;

	localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
	localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

	// only the low hash bits reach the slot index, and low product bits
	// depend only on low operand bits
	localparam int HASH_W = SLOT_BITS;
	localparam logic [HASH_W-1:0] HASH_BASIS = FNV_BASIS[HASH_W-1:0];
	localparam logic [HASH_W-1:0] HASH_PRIME = FNV_PRIME[HASH_W-1:0];

	typedef logic [SLOT_BITS-1:0] slot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_CMP
	} kvt_state_t;

	typedef enum logic [1:0] {
		STAT_FOUND    = 2'd0,
		STAT_INSERTED = 2'd1,
		STAT_NOTFOUND = 2'd2,
		STAT_FULL     = 2'd3
	} kvt_status_t;

	typedef struct packed {
		logic  done;
		slot_t home;
	} kvt_hash_stat_t;

	// bytes up to the first zero byte, the rest cleared
	function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] raw);
		logic             alive;
		logic [KEY_W-1:0] k;
		alive = 1'b1;
		k     = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'h00) alive = 1'b0;
			if (alive) k[8*i +: 8] = raw[8*i +: 8];
		end
		return k;
	endfunction

	function automatic logic [LEN_W-1:0] key_len(input logic [KEY_W-1:0] raw);
		logic             alive;
		logic [LEN_W-1:0] n;
		alive = 1'b1;
		n     = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'h00) alive = 1'b0;
			if (alive) n = n + LEN_W'(1);
		end
		return n;
	endfunction

endpackage

[hw/rtl/kvt_ram.sv]
module kvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

[hw/rtl/kvt_hash.sv]
module kvt_hash import kvt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [KEY_W-1:0]     key,
	input  logic [LEN_W-1:0]     len,
	output kvt_hash_stat_t       stat
);

	logic              run_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  len_q;
	logic [KEY_W-1:0]  key_q;
	logic [HASH_W-1:0] h_q;
	logic [HASH_W-1:0] h_d;
	logic              last;

	assign last = (cnt_q == len_q);
	// one fnv-1a round on the low byte
	assign h_d  = HASH_W'((h_q ^ HASH_W'(key_q[7:0])) * HASH_PRIME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			if (last) run_q <= 1'b0;
			else      cnt_q <= cnt_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q <= key;
			len_q <= len;
			h_q   <= HASH_BASIS;
		end else if (run_q && !last) begin
			key_q <= key_q >> 8;
			h_q   <= h_d;
		end
	end

	assign stat.done = run_q && last;
	assign stat.home = slot_t'(h_q);

endmodule

[hw/rtl/hashed_key_value_table.sv]
// hashed key/value table, open addressing with linear probing
//
// a request is taken at a clock edge where start is high and busy is low:
// mode (0 lookup, 1 set), key_bytes (ends at its first zero byte) and
// entry_value. busy stays high while the item is worked on; one item is
// in flight at a time. the result comes back on status, read_value,
// slot_index and over_load for exactly one cycle, marked by done; the
// receiver cannot stall it, and a new start may be given in that cycle.
//
// after accept, the hash unit runs one fnv-1a round per cycle over the key
// bytes; then each occupied slot probed costs a key/value memory read and
// compare. the probe ends at an empty slot, on a key match, or after every
// slot was probed. the next item is taken at the earliest at the edge that
// ends the done cycle.
//
// reset clears the slot valid flags and the occupancy count at once, so
// the table is empty and ready in the first cycle after reset.
`include "assert_macros.svh"

module hashed_key_value_table import kvt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  mode,
	input  logic [KEY_W-1:0]      key_bytes,
	input  logic [VALUE_W-1:0]    entry_value,
	output logic                  done,
	output logic [1:0]            status,
	output logic [VALUE_W-1:0]    read_value,
	output logic [SLOT_OUT_W-1:0] slot_index,
	output logic                  over_load
);

	kvt_state_t     state_q, state_d;
	kvt_hash_stat_t hash_stat;

	logic                  accept;
	logic                  mode_q;
	logic [KEY_W-1:0]      key_q;
	logic [VALUE_W-1:0]    val_q;
	slot_t                 idx_q;
	slot_t                 probe_q;
	logic [SLOTS-1:0]      valid_q;
	logic [COUNT_W-1:0]    count_q;
	logic [COUNT_W-1:0]    count_d;

	logic [ENTRY_W-1:0]    rd_data;
	logic [KEY_W-1:0]      rd_key;
	logic [VALUE_W-1:0]    rd_val;
	logic                  key_match;
	logic                  slot_hit;
	logic                  last_probe;

	logic                  rd_en;
	logic                  wr_en;
	logic                  finish;
	logic                  ins;
	logic                  advance;
	kvt_status_t           res_status;
	logic [VALUE_W-1:0]    res_value;
	logic [SLOT_OUT_W-1:0] res_slot;

	logic                  done_q;
	kvt_status_t           status_q;
	logic [VALUE_W-1:0]    rv_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic                  over_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	kvt_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.key    (canon_key(key_bytes)),
		.len    (key_len(key_bytes)),
		.stat   (hash_stat)
	);

	kvt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_q),
		.wdata ({key_q, val_q}),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	assign rd_key     = rd_data[ENTRY_W-1 -: KEY_W];
	assign rd_val     = rd_data[VALUE_W-1:0];
	assign key_match  = (rd_key == key_q);
	assign slot_hit   = valid_q[idx_q];
	assign last_probe = (probe_q == '1);
	assign count_d    = count_q + COUNT_W'(ins);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_HASH;
			ST_HASH:  if (hash_stat.done) state_d = ST_PROBE;
			ST_PROBE: state_d = slot_hit ? ST_CMP : ST_IDLE;
			ST_CMP:   state_d = (key_match || last_probe) ? ST_IDLE : ST_PROBE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		finish     = 1'b0;
		ins        = 1'b0;
		advance    = 1'b0;
		res_status = STAT_NOTFOUND;
		res_value  = '0;
		res_slot   = '0;
		case (state_q)
			ST_PROBE: begin
				if (!slot_hit) begin
					finish = 1'b1;
					if (mode_q) begin
						wr_en      = 1'b1;
						ins        = 1'b1;
						res_status = STAT_INSERTED;
						res_slot   = SLOT_OUT_W'(idx_q);
					end
				end else begin
					rd_en = 1'b1;
				end
			end
			ST_CMP: begin
				if (key_match) begin
					finish     = 1'b1;
					wr_en      = mode_q;
					res_status = STAT_FOUND;
					res_slot   = SLOT_OUT_W'(idx_q);
					if (!mode_q) res_value = rd_val;
				end else if (last_probe) begin
					// every slot held some other key
					finish     = 1'b1;
					res_status = mode_q ? STAT_FULL : STAT_NOTFOUND;
				end else begin
					advance = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			count_q <= count_d;
			if (ins) valid_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q  <= canon_key(key_bytes);
			val_q  <= entry_value;
		end
		if (state_q == ST_HASH && hash_stat.done) begin
			idx_q   <= hash_stat.home;
			probe_q <= '0;
		end else if (advance) begin
			// wraps at the end of the table
			idx_q   <= idx_q + slot_t'(1);
			probe_q <= probe_q + slot_t'(1);
		end
		if (finish) begin
			status_q <= res_status;
			rv_q     <= res_value;
			slot_q   <= res_slot;
			over_q   <= (count_d > COUNT_W'(LOAD_LIMIT));
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = rv_q;
	assign slot_index = slot_q;
	assign over_load  = over_q;

	`KVT_ASSERT(a_done_when_idle, clk, arst_n, done |-> !busy, "result shown while busy")
	`KVT_ASSERT(a_read_then_cmp, clk, arst_n, rd_en |=> (state_q == ST_CMP), "read not compared")
	`KVT_ASSERT(a_count_matches, clk, arst_n, count_q == COUNT_W'($countones(valid_q)), "count off")
	`KVT_ASSERT(a_write_on_hit, clk, arst_n, (wr_en && state_q == ST_CMP) |-> key_match, "bad update")
	`KVT_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> (!busy && !done), "active in reset")

endmodule

[bench/hashed_key_value_table_tb.sv]
module hashed_key_value_table_tb;
	import kvt_pkg::*;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_SET    = 1'b1;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int N_ROWS = 22;

	typedef struct packed {
		kvt_status_t           status;
		logic [VALUE_W-1:0]    read_value;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic                  over_load;
	} kv_reply_t;

	typedef struct packed {
		logic               mode;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic               typed;
		kv_reply_t          reply;
	} kv_row_t;

	localparam kv_reply_t NO_REPLY   = '{STAT_FOUND, 32'h0, 8'h0, 1'b0};
	localparam kv_reply_t EMPTY_MISS = '{STAT_NOTFOUND, 32'h0, 8'h0, 1'b0};
	localparam kv_reply_t FULL_MISS  = '{STAT_NOTFOUND, 32'h0, 8'h0, 1'b1};
	localparam kv_reply_t FULL_SET   = '{STAT_FULL, 32'h0, 8'h0, 1'b1};

	localparam kv_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{MODE_LOOKUP, 64'h0000_0000_0000_0000, 32'hFFFF_FFFF, 1'b1, EMPTY_MISS},
		'{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b1, EMPTY_MISS},
		'{MODE_LOOKUP, 64'h5555_5555_5555_5555, 32'h5555_5555, 1'b1, EMPTY_MISS},
		// empty key is a key of its own
		'{MODE_SET,    64'h0000_0000_0000_0000, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
		'{MODE_LOOKUP, 64'hA5A5_0000_0000_0000, 32'h0000_0000, 1'b0, NO_REPLY},
		'{MODE_SET,    64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b0, NO_REPLY},
		'{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
		'{MODE_SET,    64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0001, 1'b0, NO_REPLY},
		'{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b0, NO_REPLY},
		// bytes past the terminator do not count
		'{MODE_SET,    64'hDEAD_BEEF_0000_6261, 32'h1234_5678, 1'b0, NO_REPLY},
		'{MODE_LOOKUP, 64'h1234_5678_9A00_6261, 32'h0000_0000, 1'b0, NO_REPLY},
		'{MODE_LOOKUP, 64'h0000_0000_0000_0061, 32'h0000_0000, 1'b1, EMPTY_MISS},
		'{MODE_SET,    64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, NO_REPLY},
		'{MODE_SET,    64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, NO_REPLY},
		'{MODE_LOOKUP, 64'h5555_5555_5555_5555, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
		'{MODE_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0000_0000, 1'b0, NO_REPLY},
		'{MODE_SET,    64'h0101_0101_0101_0101, 32'h0000_0000, 1'b0, NO_REPLY},
		'{MODE_SET,    64'h0000_0000_0000_0001, 32'h0000_0001, 1'b0, NO_REPLY},
		'{MODE_LOOKUP, 64'h8080_8080_8080_8080, 32'h0000_0000, 1'b1, EMPTY_MISS},
		'{MODE_SET,    64'h7F00_0000_0000_0080, 32'h7FFF_FFFF, 1'b0, NO_REPLY},
		'{MODE_LOOKUP, 64'h0000_0000_0000_0080, 32'h0000_0000, 1'b0, NO_REPLY},
		'{MODE_LOOKUP, 64'h0101_0101_0101_0101, 32'hFFFF_FFFF, 1'b0, NO_REPLY}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  mode;
	logic [KEY_W-1:0]      key_bytes;
	logic [VALUE_W-1:0]    entry_value;
	logic                  done;
	logic [1:0]            status;
	logic [VALUE_W-1:0]    read_value;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic                  over_load;

	// shadow copy of the slot store
	logic               slot_used [SLOTS];
	logic [KEY_W-1:0]   slot_keys [SLOTS];
	logic [VALUE_W-1:0] slot_vals [SLOTS];
	int                 fill_count;

	kv_reply_t   replies_due [$];
	int          mismatches = 0;
	int unsigned cycle_count = 0;

	hashed_key_value_table i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.key_bytes   (key_bytes),
		.entry_value (entry_value),
		.done        (done),
		.status      (status),
		.read_value  (read_value),
		.slot_index  (slot_index),
		.over_load   (over_load)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [KEY_W-1:0] key_prefix(input logic [KEY_W-1:0] raw, output int n);
		logic [KEY_W-1:0] k;
		k = '0;
		n = 0;
		while (n < KEY_BYTES && raw[8*n +: 8] != 8'h00) begin
			k[8*n +: 8] = raw[8*n +: 8];
			n++;
		end
		return k;
	endfunction

	// fnv-1a home slot, then linear probe with wrap-around
	function automatic kv_reply_t apply_to_table(input logic m, input logic [KEY_W-1:0] raw,
			input logic [VALUE_W-1:0] v);
		kv_reply_t        r;
		logic [KEY_W-1:0] k;
		logic [63:0]      h;
		int               n;
		int               idx;
		logic             finished;
		k = key_prefix(raw, n);
		h = FNV_BASIS;
		for (int i = 0; i < n; i++) h = (h ^ {56'h0, k[8*i +: 8]}) * FNV_PRIME;
		idx = int'(h % 64'(SLOTS));
		r.status = STAT_NOTFOUND;
		r.read_value = '0;
		r.slot_index = '0;
		finished = 1'b0;
		for (int p = 0; p < SLOTS && !finished; p++) begin
			if (!slot_used[idx]) begin
				if (m == MODE_SET) begin
					slot_used[idx] = 1'b1;
					slot_keys[idx] = k;
					slot_vals[idx] = v;
					fill_count++;
					r.status = STAT_INSERTED;
					r.slot_index = SLOT_OUT_W'(idx);
				end
				finished = 1'b1;
			end else if (slot_keys[idx] == k) begin
				if (m == MODE_SET) slot_vals[idx] = v;
				else r.read_value = slot_vals[idx];
				r.status = STAT_FOUND;
				r.slot_index = SLOT_OUT_W'(idx);
				finished = 1'b1;
			end else begin
				idx = (idx + 1) % SLOTS;
			end
		end
		if (!finished && m == MODE_SET) r.status = STAT_FULL;
		r.over_load = (fill_count * 10 > SLOTS * 7);
		return r;
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// random bytes past the terminator
	function automatic logic [KEY_W-1:0] dressed_key(input logic [KEY_W-1:0] canon, input int n);
		logic [KEY_W-1:0] raw;
		raw = canon;
		for (int i = n + 1; i < KEY_BYTES; i++) raw[8*i +: 8] = 8'($urandom);
		return raw;
	endfunction

	function automatic logic [KEY_W-1:0] random_key();
		logic [KEY_W-1:0] canon;
		int               n;
		canon = '0;
		n = $urandom_range(0, KEY_BYTES);
		for (int i = 0; i < n; i++) canon[8*i +: 8] = 8'($urandom_range(1, 255));
		return dressed_key(canon, n);
	endfunction

	function automatic logic [KEY_W-1:0] stored_key();
		int               idx;
		int               n;
		logic [KEY_W-1:0] canon;
		do idx = $urandom_range(0, SLOTS - 1); while (!slot_used[idx]);
		canon = key_prefix(slot_keys[idx], n);
		return dressed_key(canon, n);
	endfunction

	function automatic logic key_stored(input logic [KEY_W-1:0] canon);
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i] && slot_keys[i] == canon) return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] raw;
		int               n;
		do raw = random_key(); while (key_stored(key_prefix(raw, n)));
		return raw;
	endfunction

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic send_request(input logic m, input logic [KEY_W-1:0] raw,
			input logic [VALUE_W-1:0] v, input logic typed, input kv_reply_t given);
		kv_reply_t predicted;
		@(negedge clk);
		start       <= 1'b1;
		mode        <= m;
		key_bytes   <= raw;
		entry_value <= v;
		do @(posedge clk); while (busy);
		predicted = apply_to_table(m, raw, v);
		replies_due.push_back(typed ? given : predicted);
	endtask

	task automatic random_phase(input int items, input int pct_new_set, input int pct_miss,
			input logic bursts);
		int pick;
		for (int i = 0; i < items; i++) begin
			if (bursts && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 5));
			pick = $urandom_range(0, 99);
			if (fill_count == 0 || pick < pct_new_set)
				send_request(MODE_SET, random_key(), random_value(), 1'b0, NO_REPLY);
			else if (pick < pct_new_set + pct_miss)
				send_request(MODE_LOOKUP, random_key(), random_value(), 1'b0, NO_REPLY);
			else if (pick < (100 + pct_new_set + pct_miss) / 2)
				send_request(MODE_SET, stored_key(), random_value(), 1'b0, NO_REPLY);
			else
				send_request(MODE_LOOKUP, stored_key(), random_value(), 1'b0, NO_REPLY);
		end
	endtask

	task automatic drain_replies();
		idle_cycles(1);
		while (replies_due.size() != 0) @(posedge clk);
	endtask

	function automatic void check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 40)
				$display("%0t: %s expected %0h got %0h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin
		kv_reply_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t: reply expected none got status %0d slot %0d",
						$time, status, slot_index);
			end else begin
				want = replies_due.pop_front();
				check_field("status", want.status, status);
				check_field("read_value", want.read_value, read_value);
				check_field("slot_index", want.slot_index, slot_index);
				check_field("over_load", want.over_load, over_load);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		mode        = MODE_LOOKUP;
		key_bytes   = '0;
		entry_value = '0;
		fill_count  = 0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_keys[i] = '0;
			slot_vals[i] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[i]) begin
			if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 5));
			send_request(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].value,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].reply);
		end

		// grow the table past the load threshold
		random_phase(400, 45, 15, 1'b1);

		while (fill_count < SLOTS) begin
			if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 5));
			if ($urandom_range(0, 3) == 0)
				send_request(MODE_LOOKUP, stored_key(), random_value(), 1'b0, NO_REPLY);
			else
				send_request(MODE_SET, fresh_key(), random_value(), 1'b0, NO_REPLY);
		end
		drain_replies();

		// full table: a miss scans every slot, a new key is refused
		send_request(MODE_LOOKUP, fresh_key(), random_value(), 1'b1, FULL_MISS);
		send_request(MODE_SET, fresh_key(), random_value(), 1'b1, FULL_SET);

		random_phase(550, 5, 8, 1'b1);
		random_phase(250, 5, 8, 1'b0);

		drain_replies();
		repeat (2 * SLOTS + 16) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/kvt_pkg.sv
hw/rtl/kvt_ram.sv
hw/rtl/kvt_hash.sv
hw/rtl/hashed_key_value_table.sv
bench/hashed_key_value_table_tb.sv
